// ----- sv/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define MSN_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define MSN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/msn_pkg.sv -----
// ---------------------------------------------------------------------------
// msn_pkg
// types, constants and tables for the six square metallic noise block
// ---------------------------------------------------------------------------
package msn_pkg;

  localparam int OSC_COUNT      = 6;
  localparam int FREQ_W         = 32;
  localparam int RATIO_W        = 18;
  localparam int RATIO_FRAC     = 16;
  localparam int PHASE_BITS_DEF = 32;
  localparam int LEVEL_W        = 16;
  localparam int COUNT_W        = 3;
  localparam int S_TDATA_W      = 32;
  localparam int M_TDATA_W      = 24;

  typedef logic [RATIO_W-1:0]        ratio_t;
  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic [COUNT_W-1:0]        count_t;

  // frequency ratios in q2.16, rounded to nearest
  localparam ratio_t RATIO [OSC_COUNT] = '{
    18'd65536, 18'd85459, 18'd96076, 18'd117113, 18'd126616, 18'd166199
  };

  // 0.33*count-1 in q1.15, rounded toward minus infinity
  function automatic level_t level_of(input count_t cnt);
    level_t lvl;
    unique case (cnt)
      3'd0:    lvl = -16'sd32768;
      3'd1:    lvl = -16'sd21955;
      3'd2:    lvl = -16'sd11142;
      3'd3:    lvl = -16'sd328;
      3'd4:    lvl = 16'sd10485;
      3'd5:    lvl = 16'sd21299;
      3'd6:    lvl = 16'sd32112;
      default: lvl = 16'sd32112;
    endcase
    return lvl;
  endfunction

endpackage

// ----- sv/msn_inc_stage.sv -----
// ---------------------------------------------------------------------------
// msn_inc_stage
// scales the base frequency by six ratios, clamps, registers the increments
// ---------------------------------------------------------------------------
module msn_inc_stage #(
  parameter int PHASE_BITS = msn_pkg::PHASE_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        load,
  input  logic                                        advance,
  input  logic [msn_pkg::FREQ_W-1:0]                  base_frequency,
  output logic                                        valid,
  output logic [msn_pkg::OSC_COUNT-1:0][PHASE_BITS-1:0] inc
);

  localparam int PROD_W = msn_pkg::FREQ_W + msn_pkg::RATIO_W;
  localparam int SHIFT  = msn_pkg::FREQ_W + msn_pkg::RATIO_FRAC - PHASE_BITS;
  localparam int WIDE_W = PROD_W - SHIFT;
  localparam logic [WIDE_W-1:0] LIMIT =
    WIDE_W'((64'd499 << PHASE_BITS) / 64'd1000);

  logic [msn_pkg::OSC_COUNT-1:0][PHASE_BITS-1:0] inc_next;

  for (genvar g = 0; g < msn_pkg::OSC_COUNT; g++) begin : g_osc
    logic [PROD_W-1:0] prod;
    logic [WIDE_W-1:0] wide;
    always_comb begin
      prod = {{msn_pkg::RATIO_W{1'b0}}, base_frequency} *
             {{msn_pkg::FREQ_W{1'b0}}, msn_pkg::RATIO[g]};
      wide = prod[SHIFT +: WIDE_W];
      // limit sits below full scale, so the clamped value fits
      if (wide >= LIMIT) begin
        inc_next[g] = LIMIT[PHASE_BITS-1:0];
      end else begin
        inc_next[g] = wide[PHASE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (advance) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      inc <= inc_next;
    end
  end

endmodule

// ----- sv/msn_phase_stage.sv -----
// ---------------------------------------------------------------------------
// msn_phase_stage
// six phase accumulators, top-bit count and output level register
// ---------------------------------------------------------------------------
module msn_phase_stage #(
  parameter int PHASE_BITS = msn_pkg::PHASE_BITS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          take,
  input  logic                                          out_ready,
  input  logic [msn_pkg::OSC_COUNT-1:0][PHASE_BITS-1:0] inc,
  output logic                                          out_valid,
  output msn_pkg::level_t                               noise_level,
  output msn_pkg::count_t                               high_count
);

  logic [msn_pkg::OSC_COUNT-1:0][PHASE_BITS-1:0] phase;
  logic [msn_pkg::OSC_COUNT-1:0][PHASE_BITS-1:0] phase_next;
  msn_pkg::count_t                               count_next;

  always_comb begin
    count_next = '0;
    for (int i = 0; i < msn_pkg::OSC_COUNT; i++) begin
      phase_next[i] = phase[i] + inc[i];
      count_next    = count_next + msn_pkg::COUNT_W'(phase_next[i][PHASE_BITS-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        phase     <= phase_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      high_count  <= count_next;
      noise_level <= msn_pkg::level_of(count_next);
    end
  end

endmodule

// ----- sv/six_square_metallic_noise_top.sv -----
// ---------------------------------------------------------------------------
// six_square_metallic_noise_top
// metallic noise from six square oscillators at inharmonic frequency ratios
// ---------------------------------------------------------------------------
// channel  dir  width  contents (lowest bit up)
// s_axis   in   32     base_frequency[31:0] (unsigned q0.32)
// m_axis   out  24     noise_level[15:0] (signed q1.15), high_count[18:16],
//                      zero [23:19]
//
// one transfer in and one transfer out per clock while m_tready stays high;
// each input is registered in the multiply stage, then in the accumulate stage
// rst (synchronous) clears all six phases and empties both stages
// while the result register is held by m_tready low, the increment stage
// still takes one more transfer before s_tready drops
// ---------------------------------------------------------------------------
module six_square_metallic_noise_top #(
  parameter int PHASE_BITS = msn_pkg::PHASE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // slave side
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [msn_pkg::S_TDATA_W-1:0]  s_tdata,   // base_frequency[31:0]
  // master side
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [msn_pkg::M_TDATA_W-1:0]  m_tdata    // noise_level[15:0], high_count[18:16]
);

  logic                                          s1_valid;
  logic                                          s1_advance;
  logic                                          load;
  logic                                          take;
  logic [msn_pkg::OSC_COUNT-1:0][PHASE_BITS-1:0] inc;
  msn_pkg::level_t                               noise_level;
  msn_pkg::count_t                               high_count;

  // increment stage moves on when the result register is empty or drains
  assign s1_advance = !m_tvalid || m_tready;
  assign take       = s1_valid && s1_advance;
  assign s_tready   = !s1_valid || s1_advance;
  assign load       = s_tvalid && s_tready;

  msn_inc_stage #(
    .PHASE_BITS (PHASE_BITS)
  ) u_inc (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .advance        (s1_advance),
    .base_frequency (s_tdata[msn_pkg::FREQ_W-1:0]),
    .valid          (s1_valid),
    .inc            (inc)
  );

  // phases update only when an item moves into the result register
  msn_phase_stage #(
    .PHASE_BITS (PHASE_BITS)
  ) u_phase (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .out_ready   (m_tready),
    .inc         (inc),
    .out_valid   (m_tvalid),
    .noise_level (noise_level),
    .high_count  (high_count)
  );

  // pack result fields, zero fill to whole bytes
  assign m_tdata = {{(msn_pkg::M_TDATA_W - msn_pkg::LEVEL_W - msn_pkg::COUNT_W){1'b0}},
                    high_count, noise_level};

endmodule

// ----- sv/msn_checker.sv -----
// ---------------------------------------------------------------------------
// msn_checker
// port-level checks for the six square metallic noise block
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module msn_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [msn_pkg::M_TDATA_W-1:0] m_tdata
);

  `MSN_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !m_tvalid,
                     "result valid after reset")

  `MSN_ASSERT(a_count_range, clk, rst, m_tvalid |-> (m_tdata[18:16] != 3'd7),
              "count above six")

  `MSN_ASSERT(a_level_match, clk, rst,
              m_tvalid |-> (m_tdata[15:0] == msn_pkg::level_of(m_tdata[18:16])),
              "level does not match count")

  `MSN_ASSERT(a_ready_when_empty, clk, rst, !m_tvalid |-> s_tready,
              "input stalled with empty output")

  `MSN_ASSERT(a_stall_hold, clk, rst,
              (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)),
              "stalled result changed")

endmodule

bind six_square_metallic_noise_top msn_checker u_msn_checker (.*);

// ----- test/six_square_metallic_noise_top_tb.sv -----
// ---------------------------------------------------------------------------
// six_square_metallic_noise_top_tb
// self-checking bench for the six square metallic noise block
// ---------------------------------------------------------------------------
// streams base frequencies into the slave side and predicts, for each
// accepted transfer, the count of high phase bits and the q1.15 level by
// running six phase accumulators of its own; master side transfers are
// checked in order against those predictions; both sides idle at random,
// with one stretch running flat out and one pause until the output drains
// ---------------------------------------------------------------------------
module six_square_metallic_noise_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_BITS    = 32;
  localparam int STALL_PERCENT = 38;
  localparam int RANDOM_ITEMS  = 450;
  localparam int TAIL_CYCLES   = 8;      // idle cycles run after every result is back
  localparam int WATCHDOG_MAX  = 2000;   // cycles with no transfer on either side

  // frequency ratios in q2.16: 1.0, 1.304, 1.466, 1.787, 1.932, 2.536
  localparam logic [17:0] OSC_RATIO [msn_pkg::OSC_COUNT] = '{
    18'd65536, 18'd85459, 18'd96076, 18'd117113, 18'd126616, 18'd166199
  };

  // level for each count of high phases, 0.33*count-1 in q1.15
  localparam logic signed [15:0] LEVEL_FOR_COUNT [msn_pkg::OSC_COUNT+1] = '{
    -16'sd32768, -16'sd21955, -16'sd11142, -16'sd328,
    16'sd10485, 16'sd21299, 16'sd32112
  };

  typedef struct packed {
    msn_pkg::level_t level;
    msn_pkg::count_t count;
  } noise_sample_t;

  // tracks the six phases and holds the samples the block still owes us
  class noise_level_tracker;
    logic [PHASE_BITS-1:0] phase [msn_pkg::OSC_COUNT];
    noise_sample_t         awaited_samples [$];
    int                    mismatches;

    function new();
      foreach (phase[i]) phase[i] = '0;
      mismatches = 0;
    endfunction

    task flag_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    // advance all phases by one input transfer and queue the resulting sample
    task take_frequency(input logic [msn_pkg::S_TDATA_W-1:0] base);
      logic [63:0]   inc;
      logic [63:0]   limit;
      int            high;
      noise_sample_t smp;
      limit = (64'd499 << PHASE_BITS) / 64'd1000;
      high  = 0;
      for (int i = 0; i < msn_pkg::OSC_COUNT; i++) begin
        inc = (64'(base) * 64'(OSC_RATIO[i])) >> (48 - PHASE_BITS);
        if (inc >= limit) begin
          inc = limit;
        end
        phase[i] = phase[i] + inc[PHASE_BITS-1:0];
        high += phase[i][PHASE_BITS-1];
      end
      smp.count = msn_pkg::count_t'(high);
      smp.level = LEVEL_FOR_COUNT[high];
      awaited_samples.push_back(smp);
    endtask

    // compare one output transfer with the oldest awaited sample
    task match_level(input logic [msn_pkg::M_TDATA_W-1:0] data);
      noise_sample_t smp;
      if (awaited_samples.size() == 0) begin
        flag_mismatch($sformatf("unexpected output transfer tdata=%h", data));
        return;
      end
      smp = awaited_samples.pop_front();
      if (data[15:0] !== smp.level) begin
        flag_mismatch($sformatf("noise_level %0d, expected %0d",
                                $signed(data[15:0]), smp.level));
      end
      if (data[18:16] !== smp.count) begin
        flag_mismatch($sformatf("high_count %0d, expected %0d",
                                data[18:16], smp.count));
      end
      if (data[msn_pkg::M_TDATA_W-1:19] !== '0) begin
        flag_mismatch($sformatf("padding bits %h not zero",
                                data[msn_pkg::M_TDATA_W-1:19]));
      end
    endtask
  endclass

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [msn_pkg::S_TDATA_W-1:0] s_tdata  = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [msn_pkg::M_TDATA_W-1:0] m_tdata;

  // when set, neither side inserts idle cycles
  bit steady = 1'b0;
  int quiet_cycles = 0;

  noise_level_tracker tracker = new();

  six_square_metallic_noise_top #(
    .PHASE_BITS (PHASE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #10 clk = ~clk;

  // receiver: ready drops at random, STALL_PERCENT percent of the time, unless running steady
  always @(posedge clk) begin
    m_tready <= rst ? 1'b0 : (steady || $urandom_range(99) >= STALL_PERCENT);
  end

  // monitors sample pre-edge values, so the order within the step is harmless
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        tracker.take_frequency(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        tracker.match_level(m_tdata);
      end
    end
  end

  // watchdog on cycles in which no transfer happens on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one base frequency and hold it until the transfer completes;
  // idle cycles go ahead of it, so valid is never lowered and raised in one step
  task send_frequency(input logic [msn_pkg::S_TDATA_W-1:0] base);
    while (!steady && $urandom_range(99) < STALL_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= base;
    do @(posedge clk); while (!s_tready);
  endtask

  task wait_drained();
    while (tracker.awaited_samples.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0]                   limit;
    logic [63:0]                   edge_base;
    logic [msn_pkg::S_TDATA_W-1:0] base;
    int                            pick;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero, smallest step, all ones (every increment clamped),
    // half scale and alternating bit patterns
    send_frequency(32'h0000_0000);
    send_frequency(32'h0000_0001);
    send_frequency(32'hFFFF_FFFF);
    send_frequency(32'h8000_0000);
    send_frequency(32'h5555_5555);
    send_frequency(32'hAAAA_AAAA);
    send_frequency(32'hFFFF_FFFF);
    send_frequency(32'h0000_0000);

    // large base frequency: land each oscillator just below and right at its clamp
    limit = (64'd499 << PHASE_BITS) / 64'd1000;
    for (int i = 0; i < msn_pkg::OSC_COUNT; i++) begin
      edge_base = ((limit << 16) + 64'(OSC_RATIO[i]) - 1) / 64'(OSC_RATIO[i]);
      send_frequency(edge_base[msn_pkg::S_TDATA_W-1:0] - 1'b1);
      send_frequency(edge_base[msn_pkg::S_TDATA_W-1:0]);
    end

    // random part: mostly audio-range pitches so phases wrap slowly and every
    // count shows up, plus full-range values and values near the clamp
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 150 && n < 230);
      // pause the sender once until every result is back
      if (n == 300) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait_drained();
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        base = $urandom_range(32'h0800_0000, 0);
      end else if (pick < 80) begin
        base = $urandom;
      end else begin
        base = $urandom_range(32'h7FC0_0000, 32'h3200_0000);
      end
      send_frequency(base);
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;
    // let the monitor note the last input transfer before checking the queue
    @(posedge clk);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/msn_pkg.sv
sv/msn_inc_stage.sv
sv/msn_phase_stage.sv
sv/six_square_metallic_noise_top.sv
sv/msn_checker.sv
test/six_square_metallic_noise_top_tb.sv
